/* rtl/bdrm_pkg.sv */
// ----------------------------------------------------------------------------
// bdrm_pkg
// Shared types and constants for the descriptor ratio matcher.
// ----------------------------------------------------------------------------
`default_nettype none
package bdrm_pkg;

    localparam int DESC_W  = 256;
    localparam int IDX_W   = 10;
    localparam int NODE_W  = 20;
    localparam int DIST_W  = 9;
    localparam int CFG_W   = 9;
    localparam int CNT_W   = 11;
    localparam logic [DIST_W-1:0] DIST_NONE = 9'd256;
    localparam logic [CNT_W-1:0]  CNT_MAX   = 11'd2047;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'd0,
        REG_RATIO     = 1'd1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  entry_index;
        logic [NODE_W-1:0] node_id;
        logic [63:0]       desc_w0;
        logic [63:0]       desc_w1;
        logic [63:0]       desc_w2;
        logic [63:0]       desc_w3;
        logic              has_point;
    } t_in_item;

    typedef struct packed {
        logic              match_found;
        logic [IDX_W-1:0]  query_index;
        logic [IDX_W-1:0]  match_index;
        logic [DIST_W-1:0] best_distance;
        logic [DIST_W-1:0] second_distance;
    } t_out_item;

    // Candidate presented to the distance unit
    typedef struct packed {
        logic              vld;
        logic [IDX_W-1:0]  idx;
    } t_cand;

    function automatic logic [DIST_W-1:0] popcnt64(input logic [63:0] v);
        logic [DIST_W-1:0] n;
        n = '0;
        for (int k = 0; k < 64; k++) n = n + DIST_W'(v[k]);
        return n;
    endfunction

endpackage
`default_nettype wire

/* rtl/bdrm_ram.sv */
// ----------------------------------------------------------------------------
// bdrm_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bdrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/bdrm_dist.sv */
// ----------------------------------------------------------------------------
// bdrm_dist
// Hamming distance of a stored entry against the query, with best/second
// tracking. Two register stages: popcount per word, then sum and update.
// ----------------------------------------------------------------------------
`default_nettype none
module bdrm_dist (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_init,
    input  wire bdrm_pkg::t_cand                  i_cand,
    input  wire logic [bdrm_pkg::DESC_W-1:0]      i_stored,
    input  wire logic [bdrm_pkg::DESC_W-1:0]      i_query,
    output logic                                  o_busy,
    output logic                                  o_found,
    output logic [bdrm_pkg::IDX_W-1:0]            o_best_idx,
    output logic [bdrm_pkg::DIST_W-1:0]           o_best,
    output logic [bdrm_pkg::DIST_W-1:0]           o_second
);
    import bdrm_pkg::*;

    logic              r_p_vld;
    logic [IDX_W-1:0]  r_p_idx;
    logic [DIST_W-1:0] r_pc [4];
    logic [DIST_W-1:0] w_d;
    logic [DESC_W-1:0] w_x;

    assign w_x = i_stored ^ i_query;
    assign w_d = r_pc[0] + r_pc[1] + r_pc[2] + r_pc[3];
    assign o_busy = r_p_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_cand.vld;
        end
        r_p_idx <= i_cand.idx;
        for (int k = 0; k < 4; k++) r_pc[k] <= popcnt64(w_x[k*64 +: 64]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            o_found    <= 1'b0;
            o_best     <= DIST_NONE;
            o_second   <= DIST_NONE;
            o_best_idx <= '0;
        end else if (r_p_vld) begin
            if (w_d < o_best) begin
                o_second   <= o_best;
                o_best     <= w_d;
                o_best_idx <= r_p_idx;
                o_found    <= 1'b1;
            end else if (w_d < o_second) begin
                o_second <= w_d;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/bow_descriptor_ratio_matcher.sv */
// ----------------------------------------------------------------------------
// bow_descriptor_ratio_matcher
// Node-restricted Hamming matcher with best-to-second ratio test.
// ----------------------------------------------------------------------------
// A clear sweeps the valid/used memory one entry per cycle. A query with a
// point scans: the scan reads one stored entry per cycle from the
// descriptor and status memories, then the distance pipeline drains and
// the decision is made; the result strobe o_valid pulses once in the
// cycle after. A query without point, a load or a clear produces no
// result. After reset a sweep clears the status memory with busy high.
// Results cannot be stalled.
`default_nettype none
module bow_descriptor_ratio_matcher #(
    parameter int MAX_FEATURES = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire bdrm_pkg::t_in_item   i_item,
    output logic                      o_valid,
    output bdrm_pkg::t_out_item       o_item,
    input  wire logic                 i_cfg_we,
    input  wire logic [0:0]           i_cfg_idx,
    input  wire logic [bdrm_pkg::CFG_W-1:0] i_cfg_data
);
    import bdrm_pkg::*;

    localparam int AW = $clog2(MAX_FEATURES);
    localparam int SW = NODE_W + 2; // node, valid, used

    t_state            r_state, n_state;
    logic [AW:0]       r_ptr, n_ptr;
    logic [CFG_W-1:0]  r_thr, r_ratio;
    t_in_item          r_q;
    logic [1:0]        r_drain, n_drain;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_idx;

    logic              w_acc;
    logic              s_we;
    logic [AW-1:0]     s_waddr, s_raddr;
    logic [SW-1:0]     s_wdata, s_rdata;
    logic [DESC_W-1:0] d_wdata, d_rdata;
    logic              d_we;
    logic              w_init, w_out;
    t_cand             w_cand;
    logic              w_found;
    logic [IDX_W-1:0]  w_bidx;
    logic [DIST_W-1:0] w_best, w_second;
    logic              w_dbusy;
    logic              w_match;
    logic [17:0]       w_lhs, w_rhs;
    logic              w_ld_ok;

    assign w_acc  = start && !busy;
    assign busy   = (r_state != ST_IDLE);
    assign w_ld_ok = (({{(32-IDX_W){1'b0}}, i_item.entry_index}) < 32'(MAX_FEATURES));

    // descriptor memory
    assign d_we    = w_acc && (i_item.op == OP_LOAD) && w_ld_ok;
    assign d_wdata = {i_item.desc_w3, i_item.desc_w2, i_item.desc_w1, i_item.desc_w0};

    bdrm_ram #(.WIDTH(DESC_W), .DEPTH(MAX_FEATURES)) u_desc (
        .i_clk, .i_we(d_we), .i_waddr(AW'(i_item.entry_index)), .i_wdata(d_wdata),
        .i_raddr(s_raddr), .o_rdata(d_rdata)
    );

    bdrm_ram #(.WIDTH(SW), .DEPTH(MAX_FEATURES)) u_stat (
        .i_clk, .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    // entry read in the previous cycle is a candidate when it is valid, unused and its node matches
    assign w_cand.vld = r_rd_vld && s_rdata[1] && !s_rdata[0]
                      && (s_rdata[SW-1:2] == r_q.node_id);
    assign w_cand.idx = IDX_W'(r_rd_idx);

    bdrm_dist u_dist (
        .i_clk, .i_rst_n, .i_init(w_init), .i_cand(w_cand),
        .i_stored(d_rdata),
        .i_query({r_q.desc_w3, r_q.desc_w2, r_q.desc_w1, r_q.desc_w0}),
        .o_busy(w_dbusy), .o_found(w_found), .o_best_idx(w_bidx),
        .o_best(w_best), .o_second(w_second)
    );

    assign w_lhs   = {1'b0, w_best, 8'd0};
    assign w_rhs   = 18'(r_ratio) * 18'(w_second);
    assign w_match = w_found && (w_best < r_thr) && (w_lhs < w_rhs);

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_drain = r_drain;
        s_we    = 1'b0;
        s_waddr = AW'(i_item.entry_index);
        s_wdata = {i_item.node_id, i_item.has_point, 1'b0};
        s_raddr = r_ptr[AW-1:0];
        w_init  = 1'b0;
        w_out   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    unique case (t_op'(i_item.op))
                        OP_LOAD:  s_we = w_ld_ok;
                        OP_CLEAR: begin
                            n_state = ST_CLEAR;
                            n_ptr   = '0;
                        end
                        OP_QUERY: if (i_item.has_point) begin
                            n_state = ST_SCAN;
                            n_ptr   = '0;
                            w_init  = 1'b1;
                        end
                        OP_NOP: ;
                    endcase
                end
            end
            ST_CLEAR: begin
                s_we    = 1'b1;
                s_waddr = r_ptr[AW-1:0];
                s_wdata = '0;
                n_ptr   = r_ptr + 1'b1;
                if (r_ptr == (AW+1)'(MAX_FEATURES - 1)) n_state = ST_IDLE;
            end
            ST_SCAN: begin
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == (AW+1)'(MAX_FEATURES - 1)) begin
                    n_state = ST_DRAIN;
                    n_drain = 2'd2;
                end
            end
            ST_DRAIN: begin
                n_drain = r_drain - 1'b1;
                if (r_drain == 2'd0 && !w_dbusy) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                w_out   = 1'b1;
                n_state = ST_IDLE;
                // matched entry has the query's node and is valid: mark used
                if (w_match) begin
                    s_we    = 1'b1;
                    s_waddr = AW'(w_bidx);
                    s_wdata = {r_q.node_id, 1'b1, 1'b1};
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_ptr    <= '0;
            r_drain  <= '0;
            r_rd_vld <= 1'b0;
            r_thr    <= CFG_W'(50);
            r_ratio  <= CFG_W'(192);
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_drain  <= n_drain;
            r_rd_vld <= (r_state == ST_SCAN);
            o_valid  <= w_out;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_THRESHOLD: r_thr   <= i_cfg_data;
                    REG_RATIO:     r_ratio <= i_cfg_data;
                endcase
            end
        end
        r_rd_idx <= r_ptr[AW-1:0];
        if (w_acc) r_q <= i_item;
        o_item.match_found     <= w_match;
        o_item.query_index     <= r_q.entry_index;
        o_item.match_index     <= w_match ? w_bidx : '0;
        o_item.best_distance   <= w_best;
        o_item.second_distance <= w_second;
    end

endmodule
`default_nettype wire

/* rtl/bdrm_checker.sv */
// ----------------------------------------------------------------------------
// bdrm_checker
// Port-level checks for the descriptor ratio matcher.
// ----------------------------------------------------------------------------
`default_nettype none
module bdrm_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                busy,
    input wire logic                o_valid,
    input wire bdrm_pkg::t_out_item o_item
);
    import bdrm_pkg::*;

    a_nomatch_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.match_found |-> o_item.match_index == '0)
        else $error("match_index nonzero without match");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.best_distance <= o_item.second_distance)
        else $error("best above second");
    a_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.match_found |-> o_item.best_distance != DIST_NONE)
        else $error("match without candidate");
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back results");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while busy");
endmodule

bind bow_descriptor_ratio_matcher bdrm_checker u_chk (
    .i_clk, .i_rst_n, .busy, .o_valid, .o_item
);
`default_nettype wire
